[hdl/led_chain_frame_encoder_top_macros.svh]
// Assertion macros shared by the LED chain frame encoder RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef LED_CHAIN_FRAME_ENCODER_TOP_MACROS_SVH
`define LED_CHAIN_FRAME_ENCODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LCFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define LCFE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LCFE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/lcfe_pkg.sv]
// Shared types, constants and helper functions of the LED chain frame encoder.
// No dependencies; imported by every module of the block except lcfe_ram.
package lcfe_pkg;

   localparam int REQ_DATA_W   = 40;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 16;
   localparam int RSP_USER_W   = 1;
   localparam int COUNT_REG_W  = 9;
   localparam int INDEX_W      = 10;
   // Wide enough for the index, the count register and the largest chain.
   localparam int CMP_W        = 11;
   // Store address as carried between the parts; the largest chain has 1024 LEDs.
   localparam int STORE_AW_MAX = 10;
   localparam int COLOUR_W     = 24;
   localparam int START_BYTES  = 4;
   localparam int STOP_BYTES   = 4;
   localparam int Q_DEPTH      = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam logic [7:0] FLAG_BASE = 8'hC0;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   typedef enum logic [1:0] {
      REQ_FRAME_PIXEL = 2'd0,
      REQ_INDEX_SET   = 2'd1,
      REQ_POWER_OFF   = 2'd2,
      REQ_TICK        = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      BSEL_ZERO,
      BSEL_FLAG,
      BSEL_RED,
      BSEL_GREEN,
      BSEL_BLUE
   } byte_sel_type;

   // One classified item on its way from the front part to the back part.
   typedef struct packed {
      logic                    we;
      logic                    re;
      logic [STORE_AW_MAX-1:0] addr;
      logic [COLOUR_W-1:0]     wdata;
      byte_sel_type            sel;
      logic                    byte_valid;
      logic                    frame_done;
      logic                    power_on;
      logic                    status;
   } cmd_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       frame_done;
      logic       power_on;
      logic       status;
   } result_type;

   // Colour word is {red, green, blue}.
   function automatic logic [7:0] flag_byte(input logic [COLOUR_W-1:0] rgb);
      logic [7:0] inv;
      inv = BYTE_ONES ^ {rgb[7:6], rgb[15:14], rgb[23:22], 2'b00};
      return FLAG_BASE | {2'b00, inv[7:2]};
   endfunction

   function automatic logic [7:0] select_byte(input byte_sel_type sel,
                                              input logic [COLOUR_W-1:0] rgb);
      logic [7:0] b;
      case (sel)
         BSEL_FLAG:  b = flag_byte(rgb);
         BSEL_RED:   b = rgb[23:16];
         BSEL_GREEN: b = rgb[15:8];
         BSEL_BLUE:  b = rgb[7:0];
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[hdl/lcfe_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lcfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lcfe_front.sv]
// Front part: accepts request transfers, keeps the frame and transmit control
// state and turns each item into one command for the back part. Uses lcfe_pkg.
`include "led_chain_frame_encoder_top_macros.svh"
module lcfe_front #(
   parameter int MAX_PIXELS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lcfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [lcfe_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   input  logic                              csr_wen,
   input  logic [lcfe_pkg::COUNT_REG_W-1:0]  csr_wdata,
   input  logic                              clear_busy,
   input  logic                              q_ready,
   output logic                              push,
   output lcfe_pkg::cmd_type                 cmd
);
   import lcfe_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int BPOS_W = $clog2(4 * MAX_PIXELS + START_BYTES + STOP_BYTES);

   logic [COUNT_REG_W-1:0] pixel_count_ff;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   frame_lit_ff, frame_lit_in;
   logic                   power_ff, power_in;
   logic                   sending_ff, sending_in;
   logic [BPOS_W-1:0]      bpos_ff, bpos_in;

   req_kind_type           kind;
   logic                   pixel_valid;
   logic [INDEX_W-1:0]     pixel_index;
   logic [COLOUR_W-1:0]    colour;
   logic [CNT_W-1:0]       eff_count;
   logic [BPOS_W-1:0]      pix_end;
   logic [BPOS_W-1:0]      stop_last;
   logic [BPOS_W-1:0]      rel;
   logic                   lit_next;

   assign kind        = req_kind_type'(req_tuser[1:0]);
   assign pixel_valid = req_tdata[0];
   assign pixel_index = req_tdata[10:1];
   assign colour      = {req_tdata[18:11], req_tdata[26:19], req_tdata[34:27]};

   assign req_tready = q_ready && !clear_busy;
   assign push       = req_tvalid && req_tready;

   // Counts above the store size act as the store size.
   assign eff_count = ({2'b00, pixel_count_ff} > CMP_W'(MAX_PIXELS)) ?
                      CNT_W'(MAX_PIXELS) : CNT_W'(pixel_count_ff);
   assign pix_end   = BPOS_W'(START_BYTES) + BPOS_W'({eff_count, 2'b00});
   assign stop_last = pix_end + BPOS_W'(STOP_BYTES - 1);
   assign rel       = bpos_ff - BPOS_W'(START_BYTES);

   always_comb begin
      fill_in      = fill_ff;
      frame_lit_in = frame_lit_ff;
      power_in     = power_ff;
      sending_in   = sending_ff;
      bpos_in      = bpos_ff;
      lit_next     = frame_lit_ff;
      cmd          = '0;
      cmd.sel      = BSEL_ZERO;
      cmd.wdata    = colour;
      case (kind)
         REQ_FRAME_PIXEL: begin
            if (pixel_valid && (fill_ff < eff_count)) begin
               cmd.we   = 1'b1;
               cmd.addr = STORE_AW_MAX'(fill_ff);
               lit_next = frame_lit_ff || (colour != '0);
               fill_in  = fill_ff + CNT_W'(1);
            end
            frame_lit_in = lit_next;
            if (req_tlast) begin
               power_in     = lit_next;
               frame_lit_in = 1'b0;
               fill_in      = '0;
               sending_in   = 1'b1;
               bpos_in      = '0;
            end
         end
         REQ_INDEX_SET: begin
            if ({1'b0, pixel_index} >= CMP_W'(eff_count)) begin
               cmd.status = 1'b1;
            end else begin
               cmd.we     = 1'b1;
               cmd.addr   = pixel_index;
               power_in   = 1'b1;
               sending_in = 1'b1;
               bpos_in    = '0;
            end
         end
         REQ_POWER_OFF: begin
            power_in = 1'b0;
         end
         REQ_TICK: begin
            if (sending_ff) begin
               cmd.byte_valid = 1'b1;
               if (bpos_ff < BPOS_W'(START_BYTES)) begin
                  cmd.sel = BSEL_ZERO;
               end else if (bpos_ff < pix_end) begin
                  cmd.re   = 1'b1;
                  cmd.addr = STORE_AW_MAX'(rel >> 2);
                  case (rel[1:0])
                     2'd0:    cmd.sel = BSEL_FLAG;
                     2'd1:    cmd.sel = BSEL_RED;
                     2'd2:    cmd.sel = BSEL_GREEN;
                     default: cmd.sel = BSEL_BLUE;
                  endcase
               end else if (bpos_ff >= stop_last) begin
                  cmd.frame_done = 1'b1;
               end
               if (cmd.frame_done) begin
                  sending_in = 1'b0;
                  bpos_in    = '0;
               end else begin
                  bpos_in = bpos_ff + BPOS_W'(1);
               end
            end
         end
         default: begin
            power_in = power_ff;
         end
      endcase
      cmd.power_on = power_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         fill_ff        <= '0;
         frame_lit_ff   <= 1'b0;
         power_ff       <= 1'b0;
         sending_ff     <= 1'b0;
         bpos_ff        <= '0;
      end else begin
         if (csr_wen) begin
            pixel_count_ff <= csr_wdata;
         end
         if (push) begin
            fill_ff      <= fill_in;
            frame_lit_ff <= frame_lit_in;
            power_ff     <= power_in;
            sending_ff   <= sending_in;
            bpos_ff      <= bpos_in;
         end
      end
   end

   `LCFE_ASSERT_NXT(a_frame_end_restarts, clock, reset,
      push && (kind == REQ_FRAME_PIXEL) && req_tlast,
      sending_ff && (bpos_ff == '0) && (fill_ff == '0) && !frame_lit_ff,
      "frame end did not restart the transmit and the fill")
   `LCFE_ASSERT_IMP(a_fill_in_range, clock, reset,
      push && (kind == REQ_FRAME_PIXEL) && !req_tlast && (fill_in != fill_ff),
      fill_in <= eff_count,
      "fill position stepped past the pixel count")

endmodule

[hdl/lcfe_queue.sv]
// Short command queue between the front and back parts of the encoder.
// Uses lcfe_pkg for the command type and queue depth.
`include "led_chain_frame_encoder_top_macros.svh"
module lcfe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcfe_pkg::cmd_type push_cmd,
   output logic              in_ready,
   input  logic              pop,
   output logic              out_valid,
   output lcfe_pkg::cmd_type out_cmd
);
   import lcfe_pkg::*;

   cmd_type           entries_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign in_ready  = (count_ff != QCNT_W'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LCFE_ASSERT_IMP(a_q_no_overflow, clock, reset, push, in_ready,
      "command pushed into a full queue")
   `LCFE_ASSERT_IMP(a_q_no_underflow, clock, reset, pop, out_valid,
      "command popped from an empty queue")

endmodule

[hdl/lcfe_back.sv]
// Back part: owns the colour store, clears it after reset, carries out the
// queued commands in order and holds the result register. Uses lcfe_pkg, lcfe_ram.
`include "led_chain_frame_encoder_top_macros.svh"
module lcfe_back #(
   parameter int MAX_PIXELS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  lcfe_pkg::cmd_type    q_cmd,
   output logic                 pop,
   output logic                 clear_busy,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lcfe_pkg::result_type result
);
   import lcfe_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic                clear_busy_ff, clear_busy_in;
   logic [AW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic                s1_valid_ff, s1_valid_in;
   cmd_type             s1_cmd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          result_ff;
   logic                advance;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [COLOUR_W-1:0] ram_wdata;
   logic [COLOUR_W-1:0] ram_rdata;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign pop        = q_valid && !clear_busy_ff && (!s1_valid_ff || advance);
   assign clear_busy = clear_busy_ff;

   // The clearing pass owns the write port until it has visited every entry.
   assign ram_we    = clear_busy_ff || (pop && q_cmd.we);
   assign ram_waddr = clear_busy_ff ? clr_ptr_ff : q_cmd.addr[AW-1:0];
   assign ram_wdata = clear_busy_ff ? '0 : q_cmd.wdata;

   lcfe_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (pop && q_cmd.re),
      .rd_addr (q_cmd.addr[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clr_ptr_in    = clr_ptr_ff;
      if (clear_busy_ff) begin
         if (clr_ptr_ff == AW'(MAX_PIXELS - 1)) begin
            clear_busy_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + AW'(1);
         end
      end
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_cmd_ff <= q_cmd;
      end
      if (advance && s1_valid_ff) begin
         result_ff.byte_valid <= s1_cmd_ff.byte_valid;
         result_ff.out_byte   <= select_byte(s1_cmd_ff.sel, ram_rdata);
         result_ff.frame_done <= s1_cmd_ff.frame_done;
         result_ff.power_on   <= s1_cmd_ff.power_on;
         result_ff.status     <= s1_cmd_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clr_ptr_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clr_ptr_ff    <= clr_ptr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign result     = result_ff;

   `LCFE_ASSERT_IMP(a_no_pop_while_clearing, clock, reset, clear_busy_ff, !pop,
      "command executed during the store clearing pass")
   `LCFE_ASSERT_NXT(a_clear_ends, clock, reset,
      clear_busy_ff && (clr_ptr_ff == AW'(MAX_PIXELS - 1)), !clear_busy_ff,
      "clearing pass did not end after the last entry")
   `LCFE_ASSERT_IMP(a_idle_byte_zero, clock, reset,
      rsp_valid_ff && !result_ff.byte_valid,
      (result_ff.out_byte == 8'h00) && !result_ff.frame_done,
      "byte or frame end reported without a valid byte")

endmodule

[hdl/led_chain_frame_encoder_top.sv]
// Top level of the addressable RGB LED chain frame encoder.
// Uses lcfe_pkg, lcfe_front, lcfe_queue and lcfe_back (which holds lcfe_ram).

// The encoder keeps a colour store of MAX_PIXELS pixels and turns it into the
// byte stream of an addressable RGB LED chain. Every request transfer gives
// exactly one response transfer, in order. The request kind in req_tuser is a
// frame pixel, an indexed pixel set, a power-off command or a byte tick; each
// tick during a transmit returns the next chain byte (four zero start bytes,
// then flag, red, green, blue per pixel, then four zero stop bytes, the last
// one flagged on rsp_tlast). The block takes one request per clock cycle and
// sustains one response per cycle while rsp_tready stays high and the store is
// not being cleared; a response passes from the command queue through the
// store access to the output register. The colour store is a single memory
// with one write and one registered read port, and each item uses it at most
// once. After reset the store is cleared one entry per cycle, with req_tready
// held low; the pixel count register can be written throughout. Write
// pixel_count only while no request is in flight.
module led_chain_frame_encoder_top #(
   parameter int MAX_PIXELS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata fields from bit 0: pixel_valid[0], pixel_index[10:1],
   // red[18:11], green[26:19], blue[34:27], zero fill[39:35].
   input  logic [lcfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser fields from bit 0: req_type[1:0].
   input  logic [lcfe_pkg::REQ_USER_W-1:0]   req_tuser,
   // frame_last.
   input  logic                              req_tlast,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata fields from bit 0: out_byte[7:0], power_on[8], status[9],
   // zero fill[15:10].
   output logic [lcfe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser fields from bit 0: byte_valid[0].
   output logic [lcfe_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // frame_done.
   output logic                              rsp_tlast,
   // Pixel count register.
   input  logic                              csr_wen,
   input  logic [lcfe_pkg::COUNT_REG_W-1:0]  csr_wdata
);
   import lcfe_pkg::*;

   cmd_type    front_cmd;
   cmd_type    q_cmd;
   result_type result;
   logic       push;
   logic       pop;
   logic       q_ready;
   logic       q_valid;
   logic       clear_busy;

   // The front part decides everything about an item except the store data.
   lcfe_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .clear_busy (clear_busy),
      .q_ready    (q_ready),
      .push       (push),
      .cmd        (front_cmd)
   );

   // The queue lets the front keep taking transfers while the output stalls, until it fills.
   lcfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .in_ready  (q_ready),
      .pop       (pop),
      .out_valid (q_valid),
      .out_cmd   (q_cmd)
   );

   // The back part does the store writes and reads in order and forms bytes.
   lcfe_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {6'b000000, result.status, result.power_on, result.out_byte};
   assign rsp_tuser = result.byte_valid;
   assign rsp_tlast = result.frame_done;

endmodule
